// ----- sv/mvss_pkg.sv -----
// Shared types, constants and lookup functions for the millivolt seven-segment scanner.
`default_nettype none

package mvss_pkg;

  // Field widths
  localparam int SampleBits = 10;
  localparam int RefBits    = 14;
  localparam int MvBits     = 14;
  localparam int ProdBits   = SampleBits + RefBits;

  // Largest value the four digits can show
  localparam logic [MvBits-1:0] MvMax = MvBits'(9999);

  // Constant division by 10^k: floor(x / d) = (x * m) >> RecipShift for x < 2^MvBits
  localparam int RecipBits  = 29;
  localparam int RecipShift = 28;
  localparam int MulBits    = RecipBits + MvBits;

  // Display constants
  localparam logic [7:0] DpBit   = 8'h80;
  localparam logic [1:0] DpDigit = 2'd2;
  localparam logic [3:0] DigitMax = 4'd9;

  typedef enum logic {
    ActSample = 1'b0,
    ActTick   = 1'b1
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments_n;
    logic [3:0] digit_enable;
    logic [1:0] digit_index;
  } out_item_t;

  // Scaled value of the frame and the digit slot it is shown in
  typedef struct packed {
    logic [MvBits-1:0] mv;
    logic [1:0]        pos;
  } mv_item_t;

  // Reciprocal of the place value of the digit (1000, 100, 10, 1)
  function automatic logic [RecipBits-1:0] recip_lo(input logic [1:0] pos);
    logic [RecipBits-1:0] m;
    unique case (pos)
      2'd0:    m = RecipBits'(268436);      // 1000
      2'd1:    m = RecipBits'(2684355);     // 100
      2'd2:    m = RecipBits'(26843546);    // 10
      default: m = RecipBits'(268435456);   // 1, exact
    endcase
    return m;
  endfunction

  // Reciprocal of ten times the place value (10000, 1000, 100, 10)
  function automatic logic [RecipBits-1:0] recip_hi(input logic [1:0] pos);
    logic [RecipBits-1:0] m;
    unique case (pos)
      2'd0:    m = RecipBits'(26844);       // 10000
      2'd1:    m = RecipBits'(268436);      // 1000
      2'd2:    m = RecipBits'(2684355);     // 100
      default: m = RecipBits'(26843546);    // 10
    endcase
    return m;
  endfunction

  // 0-9 font, active high, bit0 = a through bit6 = g
  function automatic logic [7:0] glyph(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      default: seg = 8'h6F;   // nine; larger codes are clamped before this
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mvss_scale.sv -----
// Input register, reference register, sample/slot state and millivolt scaling stage.
`default_nettype none

module mvss_scale (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Item input
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mvss_pkg::in_item_t          in_data,
  // Reference write
  input  wire logic                        cfg_valid,
  input  wire logic [mvss_pkg::RefBits-1:0] cfg_reference_millivolts,
  // Scaled value toward the digit stages
  output logic                             mv_valid,
  input  wire logic                        mv_ready,
  output mvss_pkg::mv_item_t               mv_data
);
  import mvss_pkg::*;

  logic                  item_valid_r;
  in_item_t              item_r;
  logic [RefBits-1:0]    ref_r;
  logic [SampleBits-1:0] latest_sample_r;
  logic [MvBits-1:0]     frame_r;
  logic [1:0]            slot_r;
  logic                  mv_valid_r;
  mv_item_t              mv_r;

  logic                  is_tick;
  logic                  mv_load;
  logic                  item_done;
  logic [ProdBits-1:0]   prod;
  logic [MvBits-1:0]     mv_full;
  logic [MvBits-1:0]     mv_sat;
  mv_item_t              mv_nxt;

  // Handshake: a sample finishes at once, a tick needs room in the next stage
  assign is_tick   = (item_r.action == ActTick);
  assign mv_load   = !mv_valid_r || mv_ready;
  assign item_done = item_valid_r && (!is_tick || mv_load);
  assign in_ready  = !item_valid_r || item_done;

  // Scale latest sample by the reference and saturate to four digits
  assign prod    = ProdBits'(latest_sample_r) * ProdBits'(ref_r);
  assign mv_full = prod[ProdBits-1:SampleBits];
  assign mv_sat  = (mv_full > MvMax) ? MvMax : mv_full;

  // Slot 0 takes the freshly scaled value, other slots reuse the latched frame
  always_comb begin
    mv_nxt.pos = slot_r;
    mv_nxt.mv  = (slot_r == 2'd0) ? mv_sat : frame_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r    <= 1'b0;
      mv_valid_r      <= 1'b0;
      ref_r           <= RefBits'(1100);
      latest_sample_r <= '0;
      frame_r         <= '0;
      slot_r          <= 2'd0;
    end else begin
      if (cfg_valid) begin
        ref_r <= cfg_reference_millivolts;
      end
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (mv_load) begin
        mv_valid_r <= item_valid_r && is_tick;
      end
      if (item_done) begin
        if (is_tick) begin
          slot_r <= slot_r + 2'd1;
          if (slot_r == 2'd0) begin
            frame_r <= mv_sat;
          end
        end else begin
          latest_sample_r <= item_r.sample;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (mv_load) begin
      mv_r <= mv_nxt;
    end
  end

  assign mv_valid = mv_valid_r;
  assign mv_data  = mv_r;

endmodule

`default_nettype wire

// ----- sv/mvss_digit.sv -----
// Digit extraction by constant reciprocals, font lookup and the result register.
`default_nettype none

module mvss_digit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Scaled value from the scaling stage
  input  wire logic               mv_valid,
  output logic                    mv_ready,
  input  wire mvss_pkg::mv_item_t mv_data,
  // Result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mvss_pkg::out_item_t     out_data
);
  import mvss_pkg::*;

  logic              q_valid_r;
  logic [MvBits-1:0] q_lo_r;
  logic [MvBits-1:0] q_hi_r;
  logic [1:0]        q_pos_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic               q_load;
  logic               out_load;
  logic [MulBits-1:0] prod_lo;
  logic [MulBits-1:0] prod_hi;
  logic [MvBits-1:0]  hi_x10;
  logic [MvBits-1:0]  diff;
  logic [3:0]         digit;
  logic [7:0]         seg;
  out_item_t          out_nxt;

  assign out_load = !out_valid_r || out_ready;
  assign q_load   = !q_valid_r || out_load;
  assign mv_ready = q_load;

  // Quotients by the place value and by ten times the place value
  assign prod_lo = MulBits'(mv_data.mv) * MulBits'(recip_lo(mv_data.pos));
  assign prod_hi = MulBits'(mv_data.mv) * MulBits'(recip_hi(mv_data.pos));

  // Digit = q_lo - 10 * q_hi, clamped to nine
  assign hi_x10 = (q_hi_r << 3) + (q_hi_r << 1);
  assign diff   = q_lo_r - hi_x10;
  assign digit  = (diff > MvBits'(DigitMax)) ? DigitMax : diff[3:0];

  // Font, decimal point on the third digit, active-low drive
  always_comb begin
    seg = glyph(digit);
    if (q_pos_r == DpDigit) begin
      seg = seg | DpBit;
    end
    out_nxt.segments_n   = ~seg;
    out_nxt.digit_enable = 4'b0001 << q_pos_r;
    out_nxt.digit_index  = q_pos_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_load) begin
        q_valid_r <= mv_valid;
      end
      if (out_load) begin
        out_valid_r <= q_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_load) begin
      q_lo_r  <= prod_lo[RecipShift +: MvBits];
      q_hi_r  <= prod_hi[RecipShift +: MvBits];
      q_pos_r <= mv_data.pos;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- sv/millivolt_seven_segment_scanner_unit.sv -----
// Millivolt seven-segment scanner: converter sample scaling and four-digit display scan.
//
// Input channel (in_valid/in_ready/in_data): action 0 stores a converter
// sample and gives no result; action 1 is a display slot tick and gives one
// result. At slot 0 the tick latches floor(sample * reference / 1024),
// saturated to 9999; each tick then shows one digit, thousands first.
// Output channel (out_valid/out_ready/out_data): active-low segments with the
// point lit on the third digit, a one-hot digit enable and the digit index.
// Config channel (cfg_valid/cfg_ready): writes the reference in millivolts;
// cfg_ready is always high. Write it only while no item is in flight.
// Path: a tick passes through the input, scale, quotient and result registers
// in that order. Throughput is one item per cycle while the receiver is ready;
// each stage has its own valid bit, so bubbles are squeezed out and a stalled
// receiver only holds the result register until the stages behind it fill.
// Reset: slot 0, stored sample and latched frame zero, reference 1100 mV,
// pipeline empty.
`default_nettype none

module millivolt_seven_segment_scanner_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire mvss_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mvss_pkg::out_item_t               out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mvss_pkg::RefBits-1:0] cfg_reference_millivolts
);
  import mvss_pkg::*;

  logic     mv_valid;
  logic     mv_ready;
  mv_item_t mv_data;

  assign cfg_ready = 1'b1;

  // Sample store, slot counter and scaling
  mvss_scale u_scale (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_data                  (in_data),
    .cfg_valid                (cfg_valid),
    .cfg_reference_millivolts (cfg_reference_millivolts),
    .mv_valid                 (mv_valid),
    .mv_ready                 (mv_ready),
    .mv_data                  (mv_data)
  );

  // Digit split and segment encode
  mvss_digit u_digit (
    .clk       (clk),
    .rst_n     (rst_n),
    .mv_valid  (mv_valid),
    .mv_ready  (mv_ready),
    .mv_data   (mv_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
